// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and character tables for the source token scanner
// Token kinds, scan modes, keyword table and character class helpers.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KW_COUNT = 7;
    localparam logic [10:0] LEN_SAT = 11'd2047;

    typedef enum logic [3:0] {
        KIND_KEYWORD    = 4'd0,
        KIND_IDENT      = 4'd1,
        KIND_INTEGER    = 4'd2,
        KIND_FLOAT      = 4'd3,
        KIND_OPERATOR   = 4'd4,
        KIND_TERMINATOR = 4'd5,
        KIND_SYMBOL     = 4'd6,
        KIND_PRINTABLE  = 4'd7,
        KIND_NONPRINT   = 4'd8
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_INT   = 3'd2,
        MODE_FLOAT = 3'd3,
        MODE_OP    = 3'd4
    } scan_mode_t;

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
        logic [10:0] len;
    } flush_t;

    typedef struct packed {
        token_kind_t kind;
        logic [9:0]  start;
        logic [10:0] len;
        logic        last;
    } token_t;

    // keyword text, left justified, zero padded to six bytes
    function automatic logic [47:0] kw_text(input logic [2:0] k);
        logic [47:0] w;
        unique case (k)
            3'd0:    w = {"int", 24'h0};
            3'd1:    w = {"float", 8'h0};
            3'd2:    w = "string";
            3'd3:    w = {"if", 32'h0};
            3'd4:    w = {"else", 16'h0};
            3'd5:    w = {"while", 8'h0};
            3'd6:    w = "return";
            default: w = 48'h0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] l;
        unique case (k)
            3'd0:    l = 3'd3;
            3'd1:    l = 3'd5;
            3'd2:    l = 3'd6;
            3'd3:    l = 3'd2;
            3'd4:    l = 3'd4;
            3'd5:    l = 3'd5;
            3'd6:    l = 3'd6;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
               c == "<" || c == ">" || c == "!" || c == "%";
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}";
    endfunction

    function automatic logic [10:0] sat_inc(input logic [10:0] l);
        return (l < LEN_SAT) ? l + 11'd1 : l;
    endfunction

    // drop keywords that no longer match once byte c lands at offset idx
    function automatic logic [KW_COUNT-1:0] kw_feed(input logic [KW_COUNT-1:0] cand,
                                                    input logic [10:0] idx,
                                                    input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        logic [47:0]         w;
        r = cand;
        for (int k = 0; k < KW_COUNT; k++) begin
            w = kw_text(3'(k));
            if (idx >= 11'(kw_len(3'(k))) ||
                w[47 - 8 * int'(idx[2:0]) -: 8] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic flush_t flush_tok(input scan_mode_t mode,
                                         input logic [KW_COUNT-1:0] cand,
                                         input logic [10:0] len);
        flush_t f;
        logic   kw;
        kw = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (cand[k] && 11'(kw_len(3'(k))) == len) begin
                kw = 1'b1;
            end
        end
        f.valid = 1'b1;
        f.len   = len;
        unique case (mode)
            MODE_WORD:  f.kind = kw ? KIND_KEYWORD : KIND_IDENT;
            MODE_INT:   f.kind = KIND_INTEGER;
            MODE_FLOAT: f.kind = KIND_FLOAT;
            MODE_OP:
            begin
                f.kind = KIND_OPERATOR;
                f.len  = 11'd1;
            end
            default:
            begin
                f.valid = 1'b0;
                f.kind  = KIND_NONPRINT;
            end
        endcase
        return f;
    endfunction

endpackage

// ===== src/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner
// Scans source text one byte per transaction and emits tokens.
// ----------------------------------------------------------------------------
// Input channel: char_byte with end_of_input, handshake in_valid / in_ready.
// Output channel: token_kind, token_start, token_length, last_of_run,
// handshake out_valid / out_ready. A byte gives zero, one or two tokens;
// last_of_run marks the final token of a byte.
// Tokens of a byte are valid in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one token and
// the receiver keeps up; a byte giving two tokens holds in_ready low while
// the second token drains from the two-entry result buffer.
// in_ready is high when the buffer is empty, or holds one token that is
// taken in the same cycle.
// A stalled receiver keeps its token stable and holds off the input once the
// buffer holds a token. End of input emits any pending token and starts a new
// text at offset 0. Bytes past MAX_INPUT give no tokens.
// Reset clears the scan state and empties the result buffer.
// ----------------------------------------------------------------------------
module source_token_scanner #(
    parameter int MAX_INPUT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [9:0]  token_start,
    output logic [10:0] token_length,
    output logic        last_of_run
);

    localparam int POS_W = $clog2(MAX_INPUT + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_INPUT);
    localparam logic [sts_pkg::KW_COUNT-1:0] CAND_ALL = '1;

    sts_pkg::scan_mode_t           mode_reg, mode_next;
    logic [9:0]                    start_reg, start_next;
    logic [10:0]                   len_reg, len_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [7:0]                    held_reg, held_next;
    logic [sts_pkg::KW_COUNT-1:0]  cand_reg, cand_next;

    sts_pkg::token_t               buf_reg [2];
    logic [1:0]                    count_reg, count_next;
    sts_pkg::token_t               res [2];
    logic [1:0]                    n_res;

    logic accept;
    logic pop;

    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign out_valid = (count_reg != 2'd0);

    assign token_kind   = buf_reg[0].kind;
    assign token_start  = buf_reg[0].start;
    assign token_length = buf_reg[0].len;
    assign last_of_run  = buf_reg[0].last;

    always_comb
    begin
        sts_pkg::flush_t f;
        logic            consumed;
        logic            final_byte;
        logic [9:0]      st;
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        cand_next  = cand_reg;
        n_res      = 2'd0;
        consumed   = 1'b0;
        final_byte = 1'b0;
        st         = 10'(pos_reg);
        f          = '0;
        for (int i = 0; i < 2; i++) begin
            res[i] = '{kind: sts_pkg::KIND_NONPRINT, start: 10'd0, len: 11'd0, last: 1'b0};
        end
        if (accept) begin
            if (pos_reg >= POS_LIMIT) begin
                // past the text limit: wait for end of input
                if (end_of_input) begin
                    mode_next  = sts_pkg::MODE_IDLE;
                    start_next = 10'd0;
                    len_next   = 11'd0;
                    pos_next   = '0;
                    held_next  = 8'd0;
                    cand_next  = CAND_ALL;
                end
            end else begin
                final_byte = end_of_input || (pos_reg == POS_LIMIT - POS_W'(1));
                unique case (mode_next)
                    sts_pkg::MODE_WORD:
                    begin
                        if (sts_pkg::is_alpha(char_byte) || sts_pkg::is_digit(char_byte) ||
                            char_byte == "_") begin
                            cand_next = sts_pkg::kw_feed(cand_next, len_next, char_byte);
                            len_next  = sts_pkg::sat_inc(len_next);
                            consumed  = 1'b1;
                        end
                    end
                    sts_pkg::MODE_INT:
                    begin
                        if (sts_pkg::is_digit(char_byte)) begin
                            len_next = sts_pkg::sat_inc(len_next);
                            consumed = 1'b1;
                        end else if (char_byte == ".") begin
                            len_next  = sts_pkg::sat_inc(len_next);
                            mode_next = sts_pkg::MODE_FLOAT;
                            consumed  = 1'b1;
                        end
                    end
                    sts_pkg::MODE_FLOAT:
                    begin
                        if (sts_pkg::is_digit(char_byte)) begin
                            len_next = sts_pkg::sat_inc(len_next);
                            consumed = 1'b1;
                        end
                    end
                    sts_pkg::MODE_OP:
                    begin
                        // two-byte operators ==, !=, <=, >=
                        if (char_byte == "=" && (held_next == "=" || held_next == "!" ||
                                                 held_next == "<" || held_next == ">")) begin
                            res[0]    = '{kind: sts_pkg::KIND_OPERATOR, start: start_next,
                                          len: 11'd2, last: 1'b0};
                            n_res     = 2'd1;
                            mode_next = sts_pkg::MODE_IDLE;
                            consumed  = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = sts_pkg::MODE_IDLE;
                    end
                endcase
                // byte ends the pending lexeme
                if (!consumed && mode_next != sts_pkg::MODE_IDLE) begin
                    f         = sts_pkg::flush_tok(mode_next, cand_next, len_next);
                    res[0]    = '{kind: f.kind, start: start_next, len: f.len, last: 1'b0};
                    n_res     = 2'd1;
                    mode_next = sts_pkg::MODE_IDLE;
                end
                if (!consumed && !sts_pkg::is_space(char_byte)) begin
                    priority if (sts_pkg::is_alpha(char_byte) || char_byte == "_") begin
                        mode_next  = sts_pkg::MODE_WORD;
                        start_next = st;
                        cand_next  = sts_pkg::kw_feed(CAND_ALL, 11'd0, char_byte);
                        len_next   = 11'd1;
                    end else if (sts_pkg::is_digit(char_byte)) begin
                        mode_next  = sts_pkg::MODE_INT;
                        start_next = st;
                        len_next   = 11'd1;
                    end else if (sts_pkg::is_op(char_byte)) begin
                        mode_next  = sts_pkg::MODE_OP;
                        start_next = st;
                        len_next   = 11'd1;
                        held_next  = char_byte;
                    end else begin
                        res[n_res[0]].start = st;
                        res[n_res[0]].len   = 11'd1;
                        if (char_byte == "#") begin
                            res[n_res[0]].kind = sts_pkg::KIND_TERMINATOR;
                        end else if (sts_pkg::is_sym(char_byte)) begin
                            res[n_res[0]].kind = sts_pkg::KIND_SYMBOL;
                        end else if (char_byte >= 8'd32 && char_byte <= 8'd126) begin
                            res[n_res[0]].kind = sts_pkg::KIND_PRINTABLE;
                        end else begin
                            res[n_res[0]].kind = sts_pkg::KIND_NONPRINT;
                        end
                        n_res = n_res + 2'd1;
                    end
                end
                if (final_byte) begin
                    if (mode_next != sts_pkg::MODE_IDLE) begin
                        f = sts_pkg::flush_tok(mode_next, cand_next, len_next);
                        res[n_res[0]] = '{kind: f.kind, start: start_next, len: f.len,
                                          last: 1'b0};
                        n_res     = n_res + 2'd1;
                        mode_next = sts_pkg::MODE_IDLE;
                    end
                    if (end_of_input) begin
                        start_next = 10'd0;
                        len_next   = 11'd0;
                        pos_next   = '0;
                        held_next  = 8'd0;
                        cand_next  = CAND_ALL;
                    end else begin
                        pos_next = POS_LIMIT;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (n_res != 2'd0) begin
                    res[n_res[1] ? 1'b1 : 1'b0].last = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept) begin
            count_next = n_res;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= sts_pkg::MODE_IDLE;
            start_reg <= 10'd0;
            len_reg   <= 11'd0;
            pos_reg   <= '0;
            held_reg  <= 8'd0;
            cand_reg  <= CAND_ALL;
            count_reg <= 2'd0;
        end else begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            cand_reg  <= cand_next;
            count_reg <= count_next;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            buf_reg[0] <= res[0];
            buf_reg[1] <= res[1];
        end else if (pop) begin
            buf_reg[0] <= buf_reg[1];
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (count_reg == 2'd0 || (count_reg == 2'd1 && out_ready)))
        else $error("byte accepted while result buffer could overflow");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !out_ready) |=> count_reg == 2'd2)
        else $error("stalled result buffer lost a token");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("byte position past limit");

    a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> (pos_reg == '0 && mode_reg == sts_pkg::MODE_IDLE))
        else $error("end of input did not restart the scan");
`endif

endmodule
